>>> sv/smv_pkg.sv
// Shared constants, codes and control/status types of the subgraph mapping verifier.
`default_nettype none

package smv_pkg;

   localparam int MAX_NODE_COUNT = 32;
   localparam int NODE_W         = $clog2(MAX_NODE_COUNT);
   localparam int COUNT_W        = NODE_W + 1;
   localparam int ROW_W          = MAX_NODE_COUNT;
   localparam int MAP_W          = 6;

   typedef enum logic [1:0] {
      ACT_PATTERN = 2'd0,
      ACT_TARGET  = 2'd1,
      ACT_MAP     = 2'd2,
      ACT_CHECK   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REASON_NONE    = 2'd0,
      REASON_RANGE   = 2'd1,
      REASON_EDGE    = 2'd2,
      REASON_REUSED  = 2'd3
   } reason_type;

   localparam logic CSR_PATTERN_COUNT = 1'b0;
   localparam logic CSR_TARGET_COUNT  = 1'b1;

   typedef struct packed {
      logic       load_pattern;
      logic       load_target;
      logic       load_map;
      logic       rd_u;
      logic       rd_tgt;
      logic       rd_map_w;
      logic       u_clear;
      logic       u_inc;
      logic       w_clear;
      logic       w_inc;
      logic       used_clear;
      logic       used_set;
      logic       out_load;
      reason_type reason;
   } ctrl_cmd_type;

   typedef struct packed {
      logic u_end;
      logic w_end;
      logic pat_edge;
      logic map_bad;
      logic edge_missing;
      logic reused;
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/smv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module smv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/smv_dp.sv
// Datapath: graph and mapping memories, node counters, used-target set and result register.
`default_nettype none

module smv_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire smv_pkg::ctrl_cmd_type          cmd,
   output smv_pkg::dp_status_type              status,
   input  wire logic [smv_pkg::NODE_W-1:0]     node_index,
   input  wire logic [smv_pkg::ROW_W-1:0]      row_bits,
   input  wire logic [smv_pkg::MAP_W-1:0]      mapped_node,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic                           csr_index,
   input  wire logic [smv_pkg::COUNT_W-1:0]    csr_data,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic                                mapping_valid,
   output logic [1:0]                          fail_reason
);
   import smv_pkg::*;

   localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_NODE_COUNT);

   logic [COUNT_W-1:0] pcount_ff, pcount_in;
   logic [COUNT_W-1:0] tcount_ff, tcount_in;
   logic [COUNT_W-1:0] u_ff, u_in;
   logic [COUNT_W-1:0] w_ff, w_in;
   logic [ROW_W-1:0]   used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               valid_ff, valid_in;
   reason_type         reason_ff, reason_in;

   logic [COUNT_W-1:0] pn;
   logic [COUNT_W-1:0] tn;
   logic [ROW_W-1:0]   pat_row;
   logic [ROW_W-1:0]   tgt_row;
   logic [MAP_W-1:0]   map_data;
   logic [NODE_W-1:0]  map_rd_addr;
   logic               map_rd_en;
   logic [NODE_W-1:0]  map_node;

   assign pn = (pcount_ff > MaxCount) ? MaxCount : pcount_ff;
   assign tn = (tcount_ff > MaxCount) ? MaxCount : tcount_ff;

   assign map_rd_addr = cmd.rd_map_w ? w_ff[NODE_W-1:0] : u_ff[NODE_W-1:0];
   assign map_rd_en   = cmd.rd_u | cmd.rd_map_w;
   assign map_node    = map_data[NODE_W-1:0];

   smv_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODE_COUNT)) u_pat_ram (
      .clock   (clock),
      .wr_en   (cmd.load_pattern),
      .wr_addr (node_index),
      .wr_data (row_bits),
      .rd_en   (cmd.rd_u),
      .rd_addr (u_ff[NODE_W-1:0]),
      .rd_data (pat_row)
   );

   smv_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODE_COUNT)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (cmd.load_target),
      .wr_addr (node_index),
      .wr_data (row_bits),
      .rd_en   (cmd.rd_tgt),
      .rd_addr (map_node),
      .rd_data (tgt_row)
   );

   smv_ram #(.WIDTH(MAP_W), .DEPTH(MAX_NODE_COUNT)) u_map_ram (
      .clock   (clock),
      .wr_en   (cmd.load_map),
      .wr_addr (node_index),
      .wr_data (mapped_node),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_data)
   );

   always_comb begin
      pcount_in    = pcount_ff;
      tcount_in    = tcount_ff;
      u_in         = u_ff;
      w_in         = w_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff;
      valid_in     = valid_ff;
      reason_in    = reason_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_COUNT: pcount_in = csr_data;
            CSR_TARGET_COUNT:  tcount_in = csr_data;
            default:           pcount_in = pcount_ff;
         endcase
      end

      if (cmd.u_clear) begin
         u_in = '0;
      end else if (cmd.u_inc) begin
         u_in = u_ff + COUNT_W'(1);
      end

      if (cmd.w_clear) begin
         w_in = '0;
      end else if (cmd.w_inc) begin
         w_in = w_ff + COUNT_W'(1);
      end

      if (cmd.used_clear) begin
         used_in = '0;
      end else if (cmd.used_set && !map_data[MAP_W-1]) begin
         used_in[map_node] = 1'b1;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         valid_in     = (cmd.reason == REASON_NONE);
         reason_in    = cmd.reason;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff    <= '0;
         tcount_ff    <= '0;
         u_ff         <= '0;
         w_ff         <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pcount_ff    <= pcount_in;
         tcount_ff    <= tcount_in;
         u_ff         <= u_in;
         w_ff         <= w_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      valid_ff  <= valid_in;
      reason_ff <= reason_in;
   end

   always_comb begin
      status.u_end        = (u_ff >= pn);
      status.w_end        = (w_ff >= pn);
      status.pat_edge     = pat_row[w_ff[NODE_W-1:0]];
      status.map_bad      = map_data[MAP_W-1] || ({1'b0, map_node} >= tn);
      status.edge_missing = !tgt_row[map_node];
      status.reused       = !map_data[MAP_W-1] && used_ff[map_node];
      status.out_busy     = rsp_valid_ff && !rsp_tready;
   end

   assign csr_ready     = 1'b1;
   assign rsp_tvalid    = rsp_valid_ff;
   assign mapping_valid = valid_ff;
   assign fail_reason   = reason_ff;

   // A new result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten while pending");

   // The node walk never runs past the node limit.
   assert property (@(posedge clock) disable iff (reset)
      u_ff <= MaxCount && w_ff <= MaxCount)
      else $error("node counter beyond limit");

   // A marked target node is recorded in the used set on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.used_set && !cmd.used_clear && !map_data[MAP_W-1]
      |=> used_ff[$past(map_node)])
      else $error("used target not recorded");

endmodule

`default_nettype wire

>>> sv/smv_ctrl.sv
// Controller: state machine that sequences loads, the edge walk and the injectivity pass.
`default_nettype none

module smv_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire smv_pkg::action_type   action,
   input  wire smv_pkg::dp_status_type status,
   output smv_pkg::ctrl_cmd_type      cmd
);
   import smv_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_U_READ  = 8'b0000_0010,
      S_U_CHECK = 8'b0000_0100,
      S_W_SCAN  = 8'b0000_1000,
      S_W_CHECK = 8'b0001_0000,
      S_I_READ  = 8'b0010_0000,
      S_I_CHECK = 8'b0100_0000,
      S_FINISH  = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   reason_type reason_ff, reason_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      reason_in  = reason_ff;
      cmd        = '0;
      cmd.reason = reason_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (action)
                  ACT_PATTERN: cmd.load_pattern = 1'b1;
                  ACT_TARGET:  cmd.load_target  = 1'b1;
                  ACT_MAP:     cmd.load_map     = 1'b1;
                  ACT_CHECK: begin
                     cmd.u_clear = 1'b1;
                     state_in    = S_U_READ;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_U_READ: begin
            if (status.u_end) begin
               cmd.u_clear    = 1'b1;
               cmd.used_clear = 1'b1;
               state_in       = S_I_READ;
            end else begin
               cmd.rd_u = 1'b1;
               state_in = S_U_CHECK;
            end
         end
         S_U_CHECK: begin
            if (status.map_bad) begin
               reason_in = REASON_RANGE;
               state_in  = S_FINISH;
            end else begin
               cmd.rd_tgt  = 1'b1;
               cmd.w_clear = 1'b1;
               state_in    = S_W_SCAN;
            end
         end
         S_W_SCAN: begin
            if (status.w_end) begin
               cmd.u_inc = 1'b1;
               state_in  = S_U_READ;
            end else if (status.pat_edge) begin
               cmd.rd_map_w = 1'b1;
               state_in     = S_W_CHECK;
            end else begin
               cmd.w_inc = 1'b1;
            end
         end
         S_W_CHECK: begin
            if (status.map_bad) begin
               reason_in = REASON_RANGE;
               state_in  = S_FINISH;
            end else if (status.edge_missing) begin
               reason_in = REASON_EDGE;
               state_in  = S_FINISH;
            end else begin
               cmd.w_inc = 1'b1;
               state_in  = S_W_SCAN;
            end
         end
         S_I_READ: begin
            if (status.u_end) begin
               reason_in = REASON_NONE;
               state_in  = S_FINISH;
            end else begin
               cmd.rd_u = 1'b1;
               state_in = S_I_CHECK;
            end
         end
         S_I_CHECK: begin
            if (status.reused) begin
               reason_in = REASON_REUSED;
               state_in  = S_FINISH;
            end else begin
               cmd.used_set = 1'b1;
               cmd.u_inc    = 1'b1;
               state_in     = S_I_READ;
            end
         end
         S_FINISH: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         reason_ff <= REASON_NONE;
      end else begin
         state_ff  <= state_in;
         reason_ff <= reason_in;
      end
   end

   // An accepted check command always starts the edge walk.
   assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_CHECK |=> state_ff == S_U_READ)
      else $error("check command did not start the walk");

   // A neighbor test is only reached from the row scan.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_W_CHECK |-> $past(state_ff) == S_W_SCAN)
      else $error("neighbor test entered out of order");

endmodule

`default_nettype wire

>>> sv/subgraph_mapping_verifier_top.sv
// Top level of the subgraph mapping verifier: stream ports, field unpacking and instances.
// A load beat (pattern row, target row or mapping entry) is taken one per cycle while idle.
// A check beat runs the edge walk, then the injectivity pass, over the first pn pattern nodes,
// with pn the clamped pattern node count, and then loads the result register; it stops early
// at the first failure.
// Reset is synchronous and active high; it clears the counts, control and result valid, while
// the row and mapping memories hold undefined data until written and get no clearing pass.
`default_nettype none

module subgraph_mapping_verifier_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // [4:0] node_index, [36:5] row_bits,
                                        // [42:37] mapped_node, [47:43] zero
   input  wire logic [1:0]  req_tuser,  // [1:0] action
   // Response stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // [0] mapping_valid, [2:1] fail_reason, [7:3] zero
   // Register write port.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [5:0]  csr_data
);
   import smv_pkg::*;

   // Unpacked request fields.
   logic [NODE_W-1:0] node_index;
   logic [ROW_W-1:0]  row_bits;
   logic [MAP_W-1:0]  mapped_node;
   action_type        action;

   // Command and status between the sequencer and the datapath.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   logic       mapping_valid;
   logic [1:0] fail_reason;

   assign node_index  = req_tdata[4:0];
   assign row_bits    = req_tdata[36:5];
   assign mapped_node = req_tdata[42:37];
   assign action      = action_type'(req_tuser);

   // The controller owns the request handshake; loads write the memories in the
   // cycle the beat is taken, and a check holds off new beats until its result is stored.
   smv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (action),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the memories, counters and the response register, so a
   // pending response does not block further loads.
   smv_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .node_index    (node_index),
      .row_bits      (row_bits),
      .mapped_node   (mapped_node),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .mapping_valid (mapping_valid),
      .fail_reason   (fail_reason)
   );

   // Pack the response beat with zero fill to a whole byte.
   assign rsp_tdata = {5'b0, fail_reason, mapping_valid};

endmodule

`default_nettype wire
